### rtl/hts_pkg.sv
package hts_pkg;

  // Temperature conversion: Q.4 degrees = floor(adc * 12491 / 4096) + 176
  localparam logic [13:0] CONV_COEF   = 14'd12491;
  localparam int          CONV_SHIFT  = 12;
  localparam int          CONV_OFFSET = 176;

  // Above 550 degrees (Q.4) the tip counts as not connected
  localparam int unsigned DISCONNECT_Q4 = 32'd8800;

  // Configuration register indexes
  localparam logic [1:0] CFG_WORK  = 2'd0;
  localparam logic [1:0] CFG_SLEEP = 2'd1;
  localparam logic [1:0] CFG_DELAY = 2'd2;

  // Configuration limits and reset values
  localparam logic [8:0]  WORK_MIN  = 9'd50;
  localparam logic [8:0]  WORK_MAX  = 9'd450;
  localparam logic [8:0]  SLEEP_MAX = 9'd450;
  localparam logic [8:0]  WORK_RST  = 9'd200;
  localparam logic [8:0]  SLEEP_RST = 9'd80;
  localparam logic [23:0] DELAY_RST = 24'd120000;

  // Sleep timer saturates at its full scale
  localparam logic [24:0] TIMER_MAX = 25'h1FFFFFF;

  // Milliseconds to seconds: floor(x / 1000) = (x * ceil(2^34 / 1000)) >> 34
  localparam int          SEC_SHIFT = 34;
  localparam logic [24:0] SEC_RECIP = 25'd17179870;

  // Mode codes on the result channel
  localparam logic [2:0] MODE_NC     = 3'd0;
  localparam logic [2:0] MODE_OFF    = 3'd1;
  localparam logic [2:0] MODE_ACTIVE = 3'd2;
  localparam logic [2:0] MODE_SLEEP  = 3'd3;
  localparam logic [2:0] MODE_HIB    = 3'd4;

  // Supervisor state, one-hot
  typedef enum logic [4:0] {
    ST_NC     = 5'b00001,
    ST_OFF    = 5'b00010,
    ST_ACTIVE = 5'b00100,
    ST_SLEEP  = 5'b01000,
    ST_HIB    = 5'b10000
  } sup_state_t;

  // Supervisor result handed from the update stage to the output stage
  typedef struct packed {
    logic [2:0] mode;
    logic [8:0] target;
    logic       written;
    logic       run;
  } sup_res_t;

  function automatic logic [2:0] mode_code(input sup_state_t st);
    logic [2:0] code;
    unique case (st)
      ST_NC:     code = MODE_NC;
      ST_OFF:    code = MODE_OFF;
      ST_ACTIVE: code = MODE_ACTIVE;
      ST_SLEEP:  code = MODE_SLEEP;
      ST_HIB:    code = MODE_HIB;
      default:   code = MODE_NC;
    endcase
    return code;
  endfunction

endpackage

### rtl/hts_front.sv
module hts_front #(
  parameter int ADC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [ADC_BITS-1:0]   adc_sample,
  input  logic                  stand_pin,
  input  logic                  enable_switch,
  output logic                  vld,
  output logic [ADC_BITS+1:0]   temp_q4,
  output logic                  stand,
  output logic                  enable
);
  import hts_pkg::*;

  localparam int PROD_W = ADC_BITS + 14;
  localparam int TEMP_W = ADC_BITS + 2;

  logic [PROD_W-1:0] prod;
  logic [TEMP_W-1:0] temp_nxt;
  logic              vld_r;
  logic [TEMP_W-1:0] temp_r;
  logic              stand_r;
  logic              enable_r;

  // Convert the raw sample to Q.4 degrees
  assign prod     = PROD_W'(adc_sample) * PROD_W'(CONV_COEF);
  assign temp_nxt = TEMP_W'(prod >> CONV_SHIFT) + TEMP_W'(CONV_OFFSET);

  // Valid of the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  // Hold the converted tick while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (en) begin
      temp_r   <= temp_nxt;
      stand_r  <= stand_pin;
      enable_r <= enable_switch;
    end
  end

  assign vld     = vld_r;
  assign temp_q4 = temp_r;
  assign stand   = stand_r;
  assign enable  = enable_r;

endmodule

### rtl/hts_core.sv
module hts_core #(
  parameter int ADC_BITS      = 12,
  parameter int TICK_MS       = 10,
  parameter int SMOOTH_WINDOW = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_in,
  input  logic [ADC_BITS+1:0]   temp_q4,
  input  logic                  stand,
  input  logic                  enable,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [23:0]           cfg_data,
  output logic                  vld,
  output hts_pkg::sup_res_t     res,
  output logic [ADC_BITS-3:0]   smooth_deg,
  output logic [23:0]           remain_ms
);
  import hts_pkg::*;

  localparam int TEMP_W  = ADC_BITS + 2;
  localparam int NUM_W   = TEMP_W + 1;
  localparam int DIV_L   = $clog2(SMOOTH_WINDOW);
  localparam int DIV_S   = NUM_W + DIV_L;
  localparam int RECIP_W = NUM_W + 1;
  localparam int PROD_W  = NUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << DIV_S)
      + 64'(SMOOTH_WINDOW) - 64'd1) / 64'(SMOOTH_WINDOW));

  // Configuration registers
  logic [8:0]  work_r;
  logic [8:0]  sleep_r;
  logic [23:0] delay_r;
  logic [8:0]  cfg_val;
  logic [8:0]  work_clamp;
  logic [8:0]  sleep_clamp;

  // Supervisor state
  sup_state_t        state_r, state_nxt;
  logic [TEMP_W-1:0] smooth_r, smooth_nxt;
  logic [24:0]       timer_r, timer_nxt;
  logic [8:0]        target_r, target_nxt;

  // Filter datapath
  logic [TEMP_W:0]    diff;
  logic               diff_neg;
  logic [TEMP_W:0]    diff_mag;
  logic [NUM_W-1:0]   num;
  logic [PROD_W-1:0]  prod;
  logic [NUM_W-1:0]   quot;
  logic [TEMP_W-1:0]  filt;

  // Supervisor datapath
  logic        adv;
  logic        disconnect;
  sup_state_t  stand_st;
  logic [25:0] timer_inc;
  logic [24:0] timer_sat;
  logic        written;
  logic        run;
  logic        hib_due;
  logic [23:0] remain_nxt;

  // Stage registers
  logic                 vld_r;
  sup_res_t             res_r;
  logic [ADC_BITS-3:0]  deg_r;
  logic [23:0]          remain_r;

  assign adv = en && vld_in;

  // Clamp the work and sleep temperature writes
  assign cfg_val     = cfg_data[8:0];
  assign work_clamp  = (cfg_val > WORK_MAX) ? WORK_MAX :
                       (cfg_val < WORK_MIN) ? WORK_MIN : cfg_val;
  assign sleep_clamp = (cfg_val > SLEEP_MAX) ? SLEEP_MAX : cfg_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_r  <= WORK_RST;
      sleep_r <= SLEEP_RST;
      delay_r <= DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WORK:  work_r  <= work_clamp;
        CFG_SLEEP: sleep_r <= sleep_clamp;
        CFG_DELAY: delay_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Smoothing: s' = s + floor((t - s) / W), division by reciprocal multiply
  assign diff     = {1'b0, temp_q4} - {1'b0, smooth_r};
  assign diff_neg = diff[TEMP_W];
  assign diff_mag = diff_neg ? -diff : diff;
  assign num      = NUM_W'(diff_mag) + (diff_neg ? NUM_W'(SMOOTH_WINDOW - 1) : '0);
  assign prod     = PROD_W'(num) * PROD_W'(RECIP);
  assign quot     = NUM_W'(prod >> DIV_S);
  assign filt     = diff_neg ? smooth_r - TEMP_W'(quot) : smooth_r + TEMP_W'(quot);

  // Sleep timer step and tip presence
  assign disconnect = 32'(temp_q4) > DISCONNECT_Q4;
  assign stand_st   = (timer_r >= {1'b0, delay_r}) ? ST_HIB : ST_SLEEP;
  assign timer_inc  = {1'b0, timer_r} + 26'(TICK_MS);
  assign timer_sat  = (timer_inc > {1'b0, TIMER_MAX}) ? TIMER_MAX : timer_inc[24:0];

  // Supervisor next state
  always_comb begin
    state_nxt  = state_r;
    smooth_nxt = smooth_r;
    timer_nxt  = timer_r;
    target_nxt = target_r;
    written    = 1'b0;
    run        = 1'b0;
    if (adv) begin
      smooth_nxt = filt;
      priority if (disconnect) begin
        target_nxt = '0;
        written    = 1'b1;
        state_nxt  = ST_NC;
      end else if (!enable) begin
        if (state_r != ST_OFF) begin
          target_nxt = '0;
          written    = 1'b1;
          state_nxt  = ST_OFF;
          timer_nxt  = '0;
        end
      end else if (stand) begin
        if (stand_st != state_r) begin
          target_nxt = (stand_st == ST_SLEEP) ? sleep_r : '0;
          written    = 1'b1;
          state_nxt  = stand_st;
        end
        if (stand_st == ST_SLEEP) begin
          timer_nxt = timer_sat;
        end
        run = 1'b1;
      end else begin
        if (state_r != ST_ACTIVE) begin
          target_nxt = work_r;
          written    = 1'b1;
          state_nxt  = ST_ACTIVE;
          timer_nxt  = '0;
        end
        run = 1'b1;
      end
    end else if (cfg_we && cfg_index == CFG_WORK && state_r == ST_ACTIVE) begin
      // A new work temperature takes effect at once while active
      target_nxt = work_clamp;
    end
  end

  // Sleep time left in milliseconds
  assign hib_due    = timer_nxt >= {1'b0, delay_r};
  assign remain_nxt = hib_due ? '0 : delay_r - timer_nxt[23:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_NC;
      smooth_r <= '0;
      timer_r  <= '0;
      target_r <= '0;
    end else begin
      state_r  <= state_nxt;
      smooth_r <= smooth_nxt;
      timer_r  <= timer_nxt;
      target_r <= target_nxt;
    end
  end

  // Result register of the update stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.mode    <= mode_code(state_nxt);
      res_r.target  <= target_nxt;
      res_r.written <= written;
      res_r.run     <= run;
      deg_r         <= smooth_nxt[TEMP_W-1:4];
      remain_r      <= remain_nxt;
    end
  end

  assign vld        = vld_r;
  assign res        = res_r;
  assign smooth_deg = deg_r;
  assign remain_ms  = remain_r;

endmodule

### rtl/hts_out.sv
module hts_out #(
  parameter int ADC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_in,
  input  hts_pkg::sup_res_t     res,
  input  logic [ADC_BITS-3:0]   smooth_deg,
  input  logic [23:0]           remain_ms,
  output logic                  out_valid,
  output logic [2:0]            out_mode,
  output logic [ADC_BITS-3:0]   out_smoothed_degrees,
  output logic [8:0]            out_pid_target,
  output logic                  out_target_written,
  output logic                  out_regulator_run,
  output logic [14:0]           out_seconds_to_hibernate
);
  import hts_pkg::*;

  logic [48:0]         sec_prod;
  logic [14:0]         secs;
  logic                vld_r;
  sup_res_t            res_r;
  logic [ADC_BITS-3:0] deg_r;
  logic [14:0]         secs_r;

  // Whole seconds left: milliseconds times the reciprocal of 1000
  assign sec_prod = 49'(remain_ms) * 49'(SEC_RECIP);
  assign secs     = 15'(sec_prod >> SEC_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res;
      deg_r  <= smooth_deg;
      secs_r <= secs;
    end
  end

  assign out_valid                = vld_r;
  assign out_mode                 = res_r.mode;
  assign out_smoothed_degrees     = deg_r;
  assign out_pid_target           = res_r.target;
  assign out_target_written       = res_r.written;
  assign out_regulator_run        = res_r.run;
  assign out_seconds_to_hibernate = secs_r;

endmodule

### rtl/heater_temperature_supervisor_top.sv
// Heater temperature supervisor. One tick (ADC sample, stand pin, enable
// switch) enters per cycle and passes registered stages in order: an input
// stage converts the sample to Q.4 degrees, an update stage runs the smoothing
// filter and the supervisor state and holds the result, and an output stage
// turns the remaining sleep time into whole seconds. Throughput is one tick
// per cycle; the whole pipeline holds while out_stall is high on a waiting
// result, and in_stall follows it in the same cycle. cfg_ready is always
// high; registers must be written only while no tick is in flight, which the
// block does not enforce. Work temperature writes clamp to 50..450 degrees and
// take effect at once while active; sleep temperature writes saturate at 450.
module heater_temperature_supervisor_top #(
  parameter int ADC_BITS      = 12,
  parameter int TICK_MS       = 10,
  parameter int SMOOTH_WINDOW = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ADC_BITS-1:0]   in_adc_sample,
  input  logic                  in_stand_pin,
  input  logic                  in_enable_switch,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_mode,
  output logic [ADC_BITS-3:0]   out_smoothed_degrees,
  output logic [8:0]            out_pid_target,
  output logic                  out_target_written,
  output logic                  out_regulator_run,
  output logic [14:0]           out_seconds_to_hibernate,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [23:0]           cfg_data
);
  import hts_pkg::*;

  logic                en;
  logic                s1_vld;
  logic [ADC_BITS+1:0] s1_temp;
  logic                s1_stand;
  logic                s1_enable;
  logic                s2_vld;
  sup_res_t            s2_res;
  logic [ADC_BITS-3:0] s2_deg;
  logic [23:0]         s2_remain;

  // Advance every stage unless a finished result is held
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  hts_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_valid),
    .adc_sample    (in_adc_sample),
    .stand_pin     (in_stand_pin),
    .enable_switch (in_enable_switch),
    .vld           (s1_vld),
    .temp_q4       (s1_temp),
    .stand         (s1_stand),
    .enable        (s1_enable)
  );

  hts_core #(
    .ADC_BITS      (ADC_BITS),
    .TICK_MS       (TICK_MS),
    .SMOOTH_WINDOW (SMOOTH_WINDOW)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .vld_in     (s1_vld),
    .temp_q4    (s1_temp),
    .stand      (s1_stand),
    .enable     (s1_enable),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .vld        (s2_vld),
    .res        (s2_res),
    .smooth_deg (s2_deg),
    .remain_ms  (s2_remain)
  );

  hts_out #(
    .ADC_BITS (ADC_BITS)
  ) u_out (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .en                       (en),
    .vld_in                   (s2_vld),
    .res                      (s2_res),
    .smooth_deg               (s2_deg),
    .remain_ms                (s2_remain),
    .out_valid                (out_valid),
    .out_mode                 (out_mode),
    .out_smoothed_degrees     (out_smoothed_degrees),
    .out_pid_target           (out_pid_target),
    .out_target_written       (out_target_written),
    .out_regulator_run        (out_regulator_run),
    .out_seconds_to_hibernate (out_seconds_to_hibernate)
  );

endmodule

### rtl/hts_checker.sv
module hts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_mode,
  input logic [8:0] out_pid_target,
  input logic       out_target_written,
  input logic       out_regulator_run
);
  import hts_pkg::*;

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // A disconnected tip always rewrites a zero target
  a_nc_target: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_mode == MODE_NC) |-> (out_pid_target == 9'd0 && out_target_written))
    else $error("not connected without zero target write");

  // Off and hibernate hold a zero target
  a_zero_target: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_mode == MODE_OFF || out_mode == MODE_HIB)) |-> out_pid_target == 9'd0)
    else $error("non-zero target while off or hibernating");

  // The regulator runs only while the tip is connected and enabled
  a_run_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_regulator_run) |->
      (out_mode == MODE_ACTIVE || out_mode == MODE_SLEEP || out_mode == MODE_HIB))
    else $error("regulator run in off or not connected");

endmodule

bind heater_temperature_supervisor_top hts_checker u_hts_checker (.*);
